// ----- hw/rtl/efr_pkg.sv -----
// Shared types and constants for the escaped frame receiver.
// Used by efr_cfg and escaped_frame_receiver; depends on nothing else.
`timescale 1ns / 1ps

package efr_pkg;

    // Largest number of data bytes kept in one frame.
    localparam int FRAME_BYTES = 128;
    // The kept-byte counter must be able to hold FRAME_BYTES itself.
    localparam int KEPT_W = $clog2(FRAME_BYTES + 1);

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [7:0] START_RST   = 8'h7b;
    localparam logic [7:0] STOP_RST    = 8'h7c;
    localparam logic [7:0] ESCAPE_RST  = 8'h7d;
    localparam logic [7:0] MAX_LEN_RST = 8'd125;

    // Register map, indexed by word address.
    typedef enum logic [1:0] {
        REG_START   = 2'd0,
        REG_STOP    = 2'd1,
        REG_ESCAPE  = 2'd2,
        REG_MAX_LEN = 2'd3
    } t_efr_reg;

    // Kind of result word.
    typedef enum logic [1:0] {
        EV_DATA    = 2'd0,
        EV_DONE    = 2'd1,
        EV_RESTART = 2'd2
    } t_efr_event;

    // Configuration handed from the register block to the parser.
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] escape_byte;
        logic [7:0] max_body_len;
    } t_efr_cfg;

endpackage

// ----- hw/rtl/escaped_frame_receiver.sv -----
// Escaped frame receiver: removes start/stop/escape byte stuffing from a byte stream.
// Each accepted byte waits in the input register until the output register is free,
// is then parsed, and its result word is registered in the output register.
// Throughput: one byte per cycle; a held result word stalls input after one more byte.
// Reset (synchronous, active low) idles the parser, clears the count, header registers
// and valid flags, and restores the configuration defaults. Uses efr_pkg, efr_cfg.
`timescale 1ns / 1ps

module escaped_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efr_pkg::APB_AW-1:0]  paddr,
    input  logic [efr_pkg::APB_DW-1:0]  pwdata,
    output logic [efr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // Received bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // Results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] data_value, [14:8] data_position, [22:15] frame_type,
    // [30:23] frame_flags, [38:31] body_len, [39] length_ok,
    // [47:40] bytes_received
    output logic [47:0]                 m_tdata,
    output logic [1:0]                  m_tuser    // [1:0] event_kind
);
    import efr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } t_phase;

    t_efr_cfg w_cfg;

    efr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // Parser state
    t_phase            r_phase, n_phase;
    logic [KEPT_W-1:0] r_kept, n_kept;
    logic [7:0]        r_hdr_type, n_hdr_type;
    logic [7:0]        r_hdr_config, n_hdr_config;
    logic [7:0]        r_hdr_length, n_hdr_length;

    // Output register
    logic              r_out_valid;
    t_efr_event        r_out_kind, n_out_kind;
    logic [7:0]        r_data_value, n_data_value;
    logic [6:0]        r_data_pos, n_data_pos;
    logic [7:0]        r_pkt_type, n_pkt_type;
    logic [7:0]        r_pkt_config, n_pkt_config;
    logic [7:0]        r_pay_len, n_pay_len;
    logic              r_len_ok, n_len_ok;
    logic [7:0]        r_bytes_rx, n_bytes_rx;
    logic              n_res_valid;

    logic w_out_free, w_fire;
    logic w_is_start, w_is_stop, w_is_esc;
    logic w_keep, w_room;

    // Handshake: parse when the output register can take a result.
    assign w_out_free = !r_out_valid || m_tready;
    assign w_fire     = r_in_valid && w_out_free;
    assign s_tready   = !r_in_valid || w_fire;

    // Framing byte decode with start before stop before escape.
    assign w_is_start = (r_in_byte == w_cfg.start_byte);
    assign w_is_stop  = !w_is_start && (r_in_byte == w_cfg.stop_byte);
    assign w_is_esc   = !w_is_start && !w_is_stop && (r_in_byte == w_cfg.escape_byte);
    assign w_room     = (r_kept < KEPT_W'(FRAME_BYTES));

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_kept       = r_kept;
        n_hdr_type   = r_hdr_type;
        n_hdr_config = r_hdr_config;
        n_hdr_length = r_hdr_length;
        n_res_valid  = 1'b0;
        n_out_kind   = EV_DATA;
        n_data_value = 8'd0;
        n_data_pos   = 7'd0;
        n_pkt_type   = 8'd0;
        n_pkt_config = 8'd0;
        n_pay_len    = 8'd0;
        n_len_ok     = 1'b0;
        n_bytes_rx   = 8'd0;
        w_keep       = 1'b0;

        unique case (r_phase)
            PH_FRAME: begin
                if (w_is_start) begin
                    n_kept      = '0;
                    n_res_valid = 1'b1;
                    n_out_kind  = EV_RESTART;
                end else if (w_is_stop) begin
                    n_phase      = PH_IDLE;
                    n_res_valid  = 1'b1;
                    n_out_kind   = EV_DONE;
                    n_pkt_type   = r_hdr_type;
                    n_pkt_config = r_hdr_config;
                    n_pay_len    = r_hdr_length;
                    n_len_ok     = (r_hdr_length <= w_cfg.max_body_len);
                    n_bytes_rx   = 8'(r_kept);
                end else if (w_is_esc) begin
                    n_phase = PH_ESC;
                end else begin
                    w_keep = 1'b1;
                end
            end
            PH_ESC: begin
                // Only a framing byte is taken as data after an escape.
                n_phase = PH_FRAME;
                w_keep  = w_is_start || w_is_stop || w_is_esc;
            end
            default: begin
                // Idle, and the unused phase code behaves the same.
                n_phase = PH_IDLE;
                if (w_is_start) begin
                    n_kept  = '0;
                    n_phase = PH_FRAME;
                end
            end
        endcase

        // Keep a data byte while the frame has room.
        if (w_keep && w_room) begin
            if (r_kept == KEPT_W'(0)) begin
                n_hdr_type = r_in_byte;
            end else if (r_kept == KEPT_W'(1)) begin
                n_hdr_config = r_in_byte;
            end else if (r_kept == KEPT_W'(2)) begin
                n_hdr_length = r_in_byte;
            end
            n_kept       = r_kept + KEPT_W'(1);
            n_res_valid  = 1'b1;
            n_out_kind   = EV_DATA;
            n_data_value = r_in_byte;
            n_data_pos   = 7'(r_kept);
        end
    end

    // State, input register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_kept       <= '0;
            r_hdr_type   <= 8'd0;
            r_hdr_config <= 8'd0;
            r_hdr_length <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (w_fire) begin
                r_phase      <= n_phase;
                r_kept       <= n_kept;
                r_hdr_type   <= n_hdr_type;
                r_hdr_config <= n_hdr_config;
                r_hdr_length <= n_hdr_length;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire && n_res_valid;
            end
        end
        // Payload registers need no reset.
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
        end
        if (w_fire && n_res_valid) begin
            r_out_kind   <= n_out_kind;
            r_data_value <= n_data_value;
            r_data_pos   <= n_data_pos;
            r_pkt_type   <= n_pkt_type;
            r_pkt_config <= n_pkt_config;
            r_pay_len    <= n_pay_len;
            r_len_ok     <= n_len_ok;
            r_bytes_rx   <= n_bytes_rx;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tdata  = {r_bytes_rx, r_len_ok, r_pay_len, r_pkt_config,
                       r_pkt_type, r_data_pos, r_data_value};

`ifndef NO_ASSERTIONS
    // The kept-byte count saturates at the frame size.
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KEPT_W'(FRAME_BYTES))
        else $error("kept-byte count exceeds frame size");

    // The count only steps up by one or restarts from zero.
    a_kept_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kept != $past(r_kept)) |->
            (r_kept == $past(r_kept) + KEPT_W'(1)) || (r_kept == '0))
        else $error("kept-byte count jumped");

    // A frame-complete word reports the length check against the limit.
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == EV_DONE) |->
            (r_len_ok == (r_pay_len <= w_cfg.max_body_len)))
        else $error("length_ok disagrees with length limit");

    // A data word carries a position below the frame size.
    a_data_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_res_valid && n_out_kind == EV_DATA) |-> w_room)
        else $error("data word produced with a full frame");
`endif

endmodule

// ----- hw/rtl/efr_cfg.sv -----
// APB-style configuration registers of the escaped frame receiver.
// Depends on efr_pkg for the register map, reset values and config struct.
`timescale 1ns / 1ps

module efr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efr_pkg::APB_AW-1:0]  paddr,
    input  logic [efr_pkg::APB_DW-1:0]  pwdata,
    output logic [efr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output efr_pkg::t_efr_cfg           o_cfg
);
    import efr_pkg::*;

    t_efr_cfg r_cfg;
    t_efr_reg w_reg;
    logic     w_write;

    assign pready  = 1'b1;
    assign w_reg   = t_efr_reg'(paddr[3:2]);
    assign w_write = psel && penable && pwrite && pready;

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte   <= START_RST;
            r_cfg.stop_byte    <= STOP_RST;
            r_cfg.escape_byte  <= ESCAPE_RST;
            r_cfg.max_body_len <= MAX_LEN_RST;
        end else if (w_write) begin
            unique case (w_reg)
                REG_START:   r_cfg.start_byte   <= pwdata[7:0];
                REG_STOP:    r_cfg.stop_byte    <= pwdata[7:0];
                REG_ESCAPE:  r_cfg.escape_byte  <= pwdata[7:0];
                REG_MAX_LEN: r_cfg.max_body_len <= pwdata[7:0];
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_reg)
            REG_START:   prdata = APB_DW'(r_cfg.start_byte);
            REG_STOP:    prdata = APB_DW'(r_cfg.stop_byte);
            REG_ESCAPE:  prdata = APB_DW'(r_cfg.escape_byte);
            REG_MAX_LEN: prdata = APB_DW'(r_cfg.max_body_len);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
